// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SOA_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SOA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/soa_pkg.sv
// ----------------------------------------------------------------------------
// soa_pkg
// Types, codes and widths of the sector owner allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int SECTORS_DEFAULT = 128;

  localparam int CMD_W    = 2;
  localparam int NAME_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int INDEX_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [NAME_W-1:0]  file_name;
    logic [COUNT_W-1:0] sector_count;
    logic [INDEX_W-1:0] sector_index;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  sectors_changed;
    logic                read_used;
    logic [NAME_W-1:0]   read_owner;
  } rsp_item_t;

  // datapath operation for the current cycle
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_CHECK,
    OP_ALLOC,
    OP_DELETE,
    OP_READ
  } dp_op_t;

  // which result word to build
  typedef enum logic [2:0] {
    RK_NONE,
    RK_ZERO,
    RK_CHANGED,
    RK_TAKEN,
    RK_SHORT,
    RK_READ
  } rsp_kind_t;

  typedef struct packed {
    logic      load;
    logic      start;
    dp_op_t    op;
    rsp_kind_t rsp;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic clear_end;
    logic hit;
    logic no_room;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/soa_req_if.sv
// ----------------------------------------------------------------------------
// soa_req_if
// Command channel: valid/ready with one command word.
// ----------------------------------------------------------------------------
interface soa_req_if;
  import soa_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// File: rtl/soa_rsp_if.sv
// ----------------------------------------------------------------------------
// soa_rsp_if
// Result channel: valid/ready with one result word.
// ----------------------------------------------------------------------------
interface soa_rsp_if;
  import soa_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// File: rtl/soa_ctrl.sv
// ----------------------------------------------------------------------------
// soa_ctrl
// Sequencer: clearing pass, name check, allocation, delete and read steps.
// ----------------------------------------------------------------------------
module soa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [soa_pkg::CMD_W-1:0]   req_command,
  output logic                        req_ready,
  output soa_pkg::dp_cmd_t            cmd,
  input  soa_pkg::dp_stat_t           stat
);
  import soa_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_CHECK  = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_ALLOC  = 8'b0001_0000,
    S_DELETE = 8'b0010_0000,
    S_READ   = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t    state, state_next;
  rsp_kind_t kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      kind  <= RK_NONE;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    req_ready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.start  = 1'b0;
    cmd.op     = OP_IDLE;
    cmd.rsp    = RK_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_end) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load  = 1'b1;
          cmd.start = 1'b1;
          unique case (req_command)
            CMD_CREATE: state_next = S_CHECK;
            CMD_DELETE: state_next = S_DELETE;
            CMD_READ:   state_next = S_READ;
            default: begin
              kind_next  = RK_ZERO;
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_CHECK: begin
        cmd.op = OP_CHECK;
        if (stat.scan_end) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.hit) begin
          kind_next  = RK_TAKEN;
          state_next = S_RESP;
        end else if (stat.no_room) begin
          kind_next  = RK_SHORT;
          state_next = S_RESP;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.op = OP_ALLOC;
        if (stat.scan_end) begin
          kind_next  = RK_CHANGED;
          state_next = S_RESP;
        end
      end
      S_DELETE: begin
        cmd.op = OP_DELETE;
        if (stat.scan_end) begin
          kind_next  = RK_CHANGED;
          state_next = S_RESP;
        end
      end
      S_READ: begin
        cmd.op     = OP_READ;
        kind_next  = RK_READ;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.rsp    = kind;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/soa_datapath.sv
// ----------------------------------------------------------------------------
// soa_datapath
// Sector table memory, scan counter, tallies and the result register.
// ----------------------------------------------------------------------------
module soa_datapath #(
  parameter int SECTORS = soa_pkg::SECTORS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  soa_pkg::req_item_t  req_item,
  input  soa_pkg::dp_cmd_t    cmd,
  output soa_pkg::dp_stat_t   stat,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output soa_pkg::rsp_item_t  rsp_item
);
  import soa_pkg::*;

  localparam int AW = $clog2(SECTORS);
  localparam int FW = $clog2(SECTORS + 1);
  localparam int CW = (FW > COUNT_W) ? FW : COUNT_W;
  localparam logic [AW-1:0] LAST = AW'(SECTORS - 1);
  localparam logic [FW-1:0] FULL = FW'(SECTORS);

  typedef struct packed {
    logic              used;
    logic [NAME_W-1:0] tag;
  } entry_t;

  entry_t    mem [SECTORS];
  entry_t    rdata;
  entry_t    wdata;
  req_item_t item_q;
  rsp_item_t rsp_next;

  logic [AW-1:0] scan_addr, rd_addr, raddr, waddr, idx_addr;
  logic          scan_more, rd_pend, hit;
  logic [FW-1:0] done, free;
  logic          scanning, reading, re, we, match, idx_ok, below_want;

  assign scanning = (cmd.op == OP_CLEAR) || (cmd.op == OP_CHECK) ||
                    (cmd.op == OP_ALLOC) || (cmd.op == OP_DELETE);
  assign reading  = (cmd.op == OP_CHECK) || (cmd.op == OP_ALLOC) ||
                    (cmd.op == OP_DELETE);

  assign match      = rd_pend && rdata.used && (rdata.tag == item_q.file_name);
  assign idx_ok     = 32'(item_q.sector_index) < SECTORS;
  assign idx_addr   = AW'(item_q.sector_index);
  assign below_want = CW'(done) < CW'(item_q.sector_count);

  assign re    = (reading && scan_more) || (cmd.op == OP_READ);
  assign raddr = (cmd.op == OP_READ) ? idx_addr : scan_addr;

  always_comb begin
    we    = 1'b0;
    waddr = rd_addr;
    wdata = rdata;
    case (cmd.op)
      OP_CLEAR: begin
        if (scan_more) begin
          we    = 1'b1;
          waddr = scan_addr;
          wdata = '0;
        end
      end
      OP_ALLOC: begin
        // lowest free sectors first, until the count is met
        if (rd_pend && !rdata.used && below_want) begin
          we         = 1'b1;
          wdata.used = 1'b1;
          wdata.tag  = item_q.file_name;
        end
      end
      OP_DELETE: begin
        if (match) begin
          we         = 1'b1;
          wdata.used = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      scan_more <= 1'b1;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
      done      <= '0;
      free      <= FULL;
    end else if (cmd.start) begin
      scan_addr <= '0;
      scan_more <= 1'b1;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
      done      <= '0;
    end else begin
      if (scanning && scan_more) begin
        if (scan_addr == LAST) scan_more <= 1'b0;
        else                   scan_addr <= scan_addr + 1'b1;
      end
      rd_pend <= reading && scan_more;
      if ((cmd.op == OP_CHECK) && match) hit <= 1'b1;
      if (we && (cmd.op == OP_ALLOC)) begin
        done <= done + 1'b1;
        free <= free - 1'b1;
      end
      if (we && (cmd.op == OP_DELETE)) begin
        done <= done + 1'b1;
        free <= free + 1'b1;
      end
    end
  end

  always_comb begin
    rsp_next = '0;
    case (cmd.rsp)
      RK_CHANGED: begin
        rsp_next.status          = ST_DONE;
        rsp_next.sectors_changed = (CW'(done) > CW'(COUNT_MAX)) ? COUNT_MAX
                                                                : COUNT_W'(done);
      end
      RK_TAKEN: rsp_next.status = ST_TAKEN;
      RK_SHORT: rsp_next.status = ST_SHORT;
      RK_READ: begin
        if (idx_ok && rdata.used) begin
          rsp_next.read_used  = 1'b1;
          rsp_next.read_owner = rdata.tag;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp != RK_NONE) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_q <= req_item;
    rd_addr <= scan_addr;
    if (cmd.rsp != RK_NONE) rsp_item <= rsp_next;
  end

  assign stat.scan_end  = rd_pend && (rd_addr == LAST);
  assign stat.clear_end = scan_more && (scan_addr == LAST);
  assign stat.hit       = hit;
  assign stat.no_room   = CW'(free) < CW'(item_q.sector_count);
  assign stat.out_free  = !rsp_valid || rsp_ready;

endmodule

// File: rtl/sector_owner_allocator_top.sv
// ----------------------------------------------------------------------------
// sector_owner_allocator_top
// Sector table that tags sectors with 16-bit owner names.
//
// req carries one command word (create, delete, read); rsp returns one
// result word per command. Both are valid/ready channels.
// Commands are handled one at a time; the table is a single-port-read memory
// scanned one sector per cycle, pipelined with the registered read data.
//   create : name scan, decide, allocation scan, result; a refused create
//            ends after the name scan and the decide step
//   delete : one scan, then result
//   read : one table read, then result; unused command : result only
// The next command can be taken in the same cycle that rsp.valid rises.
// After reset a clearing pass marks every sector free; req.ready stays low
// until it ends.
// The result sits in an output register; a new command is taken while it
// waits, and the next result is held back until rsp.ready drains it.
// ----------------------------------------------------------------------------
module sector_owner_allocator_top #(
  parameter int SECTORS = soa_pkg::SECTORS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  soa_req_if.sink    req,
  soa_rsp_if.source  rsp
);
  import soa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  soa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.item.command),
    .req_ready   (req.ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  soa_datapath #(
    .SECTORS (SECTORS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req.item),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .rsp_item  (rsp.item)
  );

endmodule

// File: rtl/soa_checker.sv
// ----------------------------------------------------------------------------
// soa_checker
// Port-level checks on the sector owner allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module soa_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input soa_pkg::rsp_item_t rsp_item
);
  import soa_pkg::*;

  // one command in flight at a time
  `SOA_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready, "command taken while busy")

  // a refused create changes nothing
  `SOA_ASSERT_SAME(a_refused_no_change, clk, rst, rsp_valid && (rsp_item.status != ST_DONE), rsp_item.sectors_changed == '0, "refused create reports changed sectors")

  // a free sector shows no owner
  `SOA_ASSERT_SAME(a_free_no_owner, clk, rst, rsp_valid && !rsp_item.read_used, rsp_item.read_owner == '0, "owner shown for free sector")

  // read results carry no status or count
  `SOA_ASSERT_SAME(a_read_clean, clk, rst, rsp_valid && rsp_item.read_used, (rsp_item.status == ST_DONE) && (rsp_item.sectors_changed == '0), "read word mixed with create/delete fields")

endmodule

bind sector_owner_allocator_top soa_checker u_soa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_item  (rsp.item)
);
